### design/sgs_pkg.sv
`default_nettype none

package sgs_pkg;

  localparam int SAMPLE_WIDTH    = 16;
  localparam int RECIP_WIDTH     = 16;
  localparam int RECIP_FRAC_BITS = 8;
  localparam int SMOOTH_WIDTH    = 16;
  localparam int SLOPE_WIDTH     = 24;

  localparam int TAPS   = 11;
  localparam int HIST   = TAPS - 1;
  localparam int FILL_W = $clog2(HIST + 1);

  localparam int SW_W   = 8;
  localparam int DW_W   = 11;
  localparam int SSUM_W = SAMPLE_WIDTH + 11;
  localparam int DSUM_W = SAMPLE_WIDTH + 12;

  localparam int SMOOTH_DIV    = 429;
  // 5148 * 2^frac = 1287 * 2^(frac + 2)
  localparam int SLOPE_DIV_ODD = 1287;
  localparam int SL_SHIFT      = RECIP_FRAC_BITS + 2;

  typedef logic signed [SAMPLE_WIDTH-1:0] sample_t;
  typedef logic        [RECIP_WIDTH-1:0]  recip_t;
  typedef logic signed [SMOOTH_WIDTH-1:0] smooth_t;
  typedef logic signed [SLOPE_WIDTH-1:0]  slope_t;
  typedef logic signed [SW_W-1:0]         sw_t;
  typedef logic signed [DW_W-1:0]         dw_t;
  typedef logic signed [SSUM_W-1:0]       ssum_t;
  typedef logic signed [DSUM_W-1:0]       dsum_t;

  typedef struct packed {
    ssum_t ssum;
    dsum_t dsum;
    logic  full;
  } sums_t;

  localparam recip_t RECIP_RESET = RECIP_WIDTH'(1 << RECIP_FRAC_BITS);

  localparam smooth_t SMOOTH_MAX = {1'b0, {(SMOOTH_WIDTH-1){1'b1}}};
  localparam smooth_t SMOOTH_MIN = {1'b1, {(SMOOTH_WIDTH-1){1'b0}}};

  localparam sw_t SMOOTH_WGT [TAPS] = '{
    -8'sd36, 8'sd9, 8'sd44, 8'sd69, 8'sd84, 8'sd89,
    8'sd84, 8'sd69, 8'sd44, 8'sd9, -8'sd36
  };

  localparam dw_t SLOPE_WGT [TAPS] = '{
    11'sd300, -11'sd294, -11'sd532, -11'sd503, -11'sd296, 11'sd0,
    11'sd296, 11'sd503, 11'sd532, 11'sd294, -11'sd300
  };

endpackage

`default_nettype wire

### design/sgs_in_if.sv
`default_nettype none

interface sgs_in_if;
  import sgs_pkg::*;

  logic    valid;
  logic    ready;
  sample_t sample;

  modport source (output valid, output sample, input ready);
  modport sink (input valid, input sample, output ready);
endinterface

`default_nettype wire

### design/sgs_out_if.sv
`default_nettype none

interface sgs_out_if;
  import sgs_pkg::*;

  logic    valid;
  logic    ready;
  smooth_t smoothed;
  slope_t  slope;
  logic    window_full;

  modport source (output valid, output smoothed, output slope, output window_full,
                  input ready);
  modport sink (input valid, input smoothed, input slope, input window_full,
                output ready);
endinterface

`default_nettype wire

### design/savitzky_golay_smooth_and_slope_core.sv
`default_nettype none

// Eleven-point Savitzky-Golay smoother and differentiator. Each accepted sample
// closes a window with the ten samples before it and gives one result: the
// quadratic smoothed centre value (weights over 429, rounded half away from
// zero, saturated to 16 bits), the cubic first derivative scaled by the
// unsigned Q8.8 recip_interval register (reset 256, i.e. 1.0) and rounded once,
// and window_full, set from the eleventh sample after reset on. Samples held
// before that count as zero. A chain of ten tap cells keeps running partial
// sums instead of a sample history, so a new sample is taken every cycle
// while the pipeline has room; each result is registered through the
// reciprocal-multiply division pipeline behind the chain. A stalled output
// holds the pipeline, which keeps taking samples until its seven stages are
// full. Write recip_interval only while no sample is in flight.
module savitzky_golay_smooth_and_slope_core (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            cfg_we,
  input  wire sgs_pkg::recip_t cfg_wdata,
  sgs_in_if.sink               in_ch,
  sgs_out_if.source            out_ch
);
  import sgs_pkg::*;

  recip_t            recip_r;
  logic [FILL_W-1:0] fill_r;
  logic [FILL_W-1:0] fill_nxt;
  logic              accept;
  logic              post_ready;
  sums_t             sums;
  ssum_t             s_link [HIST+1];
  dsum_t             d_link [HIST+1];

  assign accept       = in_ch.valid && post_ready;
  assign in_ch.ready  = post_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      recip_r <= RECIP_RESET;
    end else if (cfg_we) begin
      recip_r <= cfg_wdata;
    end
  end

  assign fill_nxt = (fill_r == FILL_W'(HIST)) ? fill_r : fill_r + FILL_W'(1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= '0;
    end else if (accept) begin
      fill_r <= fill_nxt;
    end
  end

  assign s_link[0] = '0;
  assign d_link[0] = '0;

  for (genvar j = 0; j < HIST; j++) begin : g_cell
    sgs_cell u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .en     (accept),
      .sample (in_ch.sample),
      .w_s    (SMOOTH_WGT[j]),
      .w_d    (SLOPE_WGT[j]),
      .s_in   (s_link[j]),
      .d_in   (d_link[j]),
      .s_out  (s_link[j+1]),
      .d_out  (d_link[j+1])
    );
  end

  // newest tap closes the window
  assign sums.ssum = s_link[HIST] + SSUM_W'(SMOOTH_WGT[HIST]) * SSUM_W'(in_ch.sample);
  assign sums.dsum = d_link[HIST] + DSUM_W'(SLOPE_WGT[HIST]) * DSUM_W'(in_ch.sample);
  assign sums.full = (fill_r == FILL_W'(HIST));

  sgs_post u_post (
    .clk    (clk),
    .rst_n  (rst_n),
    .take   (accept),
    .ready  (post_ready),
    .sums   (sums),
    .recip  (recip_r),
    .out_ch (out_ch)
  );

endmodule

`default_nettype wire

### design/sgs_cell.sv
`default_nettype none

module sgs_cell (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           en,
  input  wire sgs_pkg::sample_t sample,
  input  wire sgs_pkg::sw_t     w_s,
  input  wire sgs_pkg::dw_t     w_d,
  input  wire sgs_pkg::ssum_t   s_in,
  input  wire sgs_pkg::dsum_t   d_in,
  output sgs_pkg::ssum_t        s_out,
  output sgs_pkg::dsum_t        d_out
);
  import sgs_pkg::*;

  ssum_t s_r, s_nxt;
  dsum_t d_r, d_nxt;

  // partial sums of the transposed tap chain
  assign s_nxt = s_in + SSUM_W'(w_s) * SSUM_W'(sample);
  assign d_nxt = d_in + DSUM_W'(w_d) * DSUM_W'(sample);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s_r <= '0;
      d_r <= '0;
    end else if (en) begin
      s_r <= s_nxt;
      d_r <= d_nxt;
    end
  end

  assign s_out = s_r;
  assign d_out = d_r;

endmodule

`default_nettype wire

### design/sgs_post.sv
`default_nettype none

module sgs_post (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            take,
  output logic                 ready,
  input  wire sgs_pkg::sums_t  sums,
  input  wire sgs_pkg::recip_t recip,
  sgs_out_if.source            out_ch
);
  import sgs_pkg::*;

  localparam int NSTG     = 7;
  localparam int SMAG_W   = 25;
  localparam int SQ_W     = 17;
  localparam int SM_K     = 25;
  localparam int SM_RECIP = 78215;
  localparam int SM_PW    = SMAG_W + 17;
  localparam int PROD_W   = DSUM_W + RECIP_WIDTH + 1;
  localparam int SL_HALF  = SLOPE_DIV_ODD << (SL_SHIFT - 1);
  localparam int U_W      = 33;
  localparam int UL_W     = 17;
  localparam int UH_W     = U_W - UL_W;
  localparam int QH_W     = 6;
  localparam int QH_K     = 16;
  localparam int QH_RECIP = 50;
  localparam int QHP_W    = UH_W + 6;
  localparam int RH_W     = 11;
  localparam int V_W      = RH_W + UL_W;
  localparam int QL_W     = 17;
  localparam int QL_K     = 28;
  localparam int QL_RECIP = 208574;
  localparam int QLP_W    = V_W + 18;
  localparam int Q_W      = QH_W + QL_W;

  logic [NSTG-1:0] v_r;
  logic [NSTG-1:0] adv;

  // stage registers
  sums_t                   s0_r;
  logic [SMAG_W-1:0]       s1_smag_r;
  logic                    s1_sneg_r;
  logic signed [PROD_W-1:0] s1_prod_r;
  logic                    s1_full_r;
  logic [SQ_W-1:0]         s2_sq0_r;
  logic [SMAG_W-1:0]       s2_smag_r;
  logic                    s2_sneg_r;
  logic [U_W-1:0]          s2_u_r;
  logic                    s2_dneg_r;
  logic                    s2_full_r;
  smooth_t                 s3_sm_r;
  logic [QH_W-1:0]         s3_qh0_r;
  logic [UH_W-1:0]         s3_uh_r;
  logic [UL_W-1:0]         s3_ul_r;
  logic                    s3_dneg_r;
  logic                    s3_full_r;
  smooth_t                 s4_sm_r;
  logic [QH_W-1:0]         s4_qh_r;
  logic [V_W-1:0]          s4_v_r;
  logic                    s4_dneg_r;
  logic                    s4_full_r;
  smooth_t                 s5_sm_r;
  logic [QH_W-1:0]         s5_qh_r;
  logic [QL_W-1:0]         s5_ql0_r;
  logic [V_W-1:0]          s5_v_r;
  logic                    s5_dneg_r;
  logic                    s5_full_r;
  smooth_t                 out_sm_r;
  slope_t                  out_sl_r;
  logic                    out_full_r;

  // next values
  logic [SSUM_W-1:0]        ssum_abs;
  logic [SMAG_W-1:0]        smag_nxt;
  logic signed [RECIP_WIDTH:0] recip_s;
  logic signed [PROD_W-1:0] prod_nxt;
  logic [SM_PW-1:0]         sm_est;
  logic [SQ_W-1:0]          sq0_nxt;
  logic [PROD_W-1:0]        prod_abs;
  logic [PROD_W-1:0]        prod_rnd;
  logic [U_W-1:0]           u_nxt;
  logic [SMAG_W-1:0]        sq_mul;
  logic [SMAG_W-1:0]        sm_rem;
  logic [SQ_W-1:0]          sm_q;
  logic [SQ_W-1:0]          sm_qneg;
  smooth_t                  sm_nxt;
  logic [QHP_W-1:0]         qh_est;
  logic [QH_W-1:0]          qh0_nxt;
  logic [UH_W-1:0]          qh_mul;
  logic [UH_W-1:0]          rh0;
  logic [UH_W-1:0]          rh;
  logic [QH_W-1:0]          qh_nxt;
  logic [V_W-1:0]           v_nxt;
  logic [QLP_W-1:0]         ql_est;
  logic [QL_W-1:0]          ql0_nxt;
  logic [V_W-1:0]           ql_mul;
  logic [V_W-1:0]           rl;
  logic [QL_W-1:0]          ql;
  logic [Q_W-1:0]           q_slope;
  slope_t                   sl_nxt;

  // stall chain, a stage moves when it is empty or the next one moves
  always_comb begin
    adv[NSTG-1] = !v_r[NSTG-1] || out_ch.ready;
    for (int k = NSTG - 2; k >= 0; k--) begin
      adv[k] = !v_r[k] || adv[k+1];
    end
  end

  assign ready = adv[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (adv[0]) begin
        v_r[0] <= take;
      end
      for (int k = 1; k < NSTG; k++) begin
        if (adv[k]) begin
          v_r[k] <= v_r[k-1];
        end
      end
    end
  end

  // smoothing magnitude and slope product
  always_comb begin
    ssum_abs = s0_r.ssum[SSUM_W-1] ? -s0_r.ssum : s0_r.ssum;
    smag_nxt = SMAG_W'(ssum_abs) + SMAG_W'(SMOOTH_DIV / 2);
    recip_s  = {1'b0, recip};
    prod_nxt = PROD_W'(s0_r.dsum) * PROD_W'(recip_s);
  end

  // smoothed reciprocal estimate, slope rounding offset and first scaling
  always_comb begin
    sm_est   = SM_PW'(s1_smag_r) * SM_PW'(SM_RECIP);
    sq0_nxt  = sm_est[SM_K +: SQ_W];
    prod_abs = s1_prod_r[PROD_W-1] ? -s1_prod_r : s1_prod_r;
    prod_rnd = prod_abs + PROD_W'(SL_HALF);
    u_nxt    = prod_rnd[SL_SHIFT +: U_W];
  end

  // smoothed correction and saturation, upper slope quotient estimate
  always_comb begin
    sq_mul  = SMAG_W'(s2_sq0_r) * SMAG_W'(SMOOTH_DIV);
    sm_rem  = s2_smag_r - sq_mul;
    sm_q    = (sm_rem >= SMAG_W'(SMOOTH_DIV)) ? s2_sq0_r + SQ_W'(1) : s2_sq0_r;
    sm_qneg = -sm_q;
    if (s2_sneg_r) begin
      sm_nxt = (sm_q > SQ_W'(1 << (SMOOTH_WIDTH - 1))) ? SMOOTH_MIN
                                                       : sm_qneg[SMOOTH_WIDTH-1:0];
    end else begin
      sm_nxt = (sm_q > SQ_W'(SMOOTH_MAX)) ? SMOOTH_MAX : sm_q[SMOOTH_WIDTH-1:0];
    end
    qh_est  = QHP_W'(s2_u_r[U_W-1 -: UH_W]) * QHP_W'(QH_RECIP);
    qh0_nxt = qh_est[QH_K +: QH_W];
  end

  // upper quotient correction
  always_comb begin
    qh_mul = UH_W'(s3_qh0_r) * UH_W'(SLOPE_DIV_ODD);
    rh0    = s3_uh_r - qh_mul;
    if (rh0 >= UH_W'(SLOPE_DIV_ODD)) begin
      qh_nxt = s3_qh0_r + QH_W'(1);
      rh     = rh0 - UH_W'(SLOPE_DIV_ODD);
    end else begin
      qh_nxt = s3_qh0_r;
      rh     = rh0;
    end
    v_nxt = {rh[RH_W-1:0], s3_ul_r};
  end

  // lower quotient estimate
  always_comb begin
    ql_est  = QLP_W'(s4_v_r) * QLP_W'(QL_RECIP);
    ql0_nxt = ql_est[QL_K +: QL_W];
  end

  // lower quotient correction and sign
  always_comb begin
    ql_mul  = V_W'(s5_ql0_r) * V_W'(SLOPE_DIV_ODD);
    rl      = s5_v_r - ql_mul;
    ql      = (rl >= V_W'(SLOPE_DIV_ODD)) ? s5_ql0_r + QL_W'(1) : s5_ql0_r;
    q_slope = {s5_qh_r, ql};
    sl_nxt  = s5_dneg_r ? -SLOPE_WIDTH'(q_slope) : SLOPE_WIDTH'(q_slope);
  end

  always_ff @(posedge clk) begin
    if (adv[0]) begin
      s0_r <= sums;
    end
    if (adv[1]) begin
      s1_smag_r <= smag_nxt;
      s1_sneg_r <= s0_r.ssum[SSUM_W-1];
      s1_prod_r <= prod_nxt;
      s1_full_r <= s0_r.full;
    end
    if (adv[2]) begin
      s2_sq0_r  <= sq0_nxt;
      s2_smag_r <= s1_smag_r;
      s2_sneg_r <= s1_sneg_r;
      s2_u_r    <= u_nxt;
      s2_dneg_r <= s1_prod_r[PROD_W-1];
      s2_full_r <= s1_full_r;
    end
    if (adv[3]) begin
      s3_sm_r   <= sm_nxt;
      s3_qh0_r  <= qh0_nxt;
      s3_uh_r   <= s2_u_r[U_W-1 -: UH_W];
      s3_ul_r   <= s2_u_r[UL_W-1:0];
      s3_dneg_r <= s2_dneg_r;
      s3_full_r <= s2_full_r;
    end
    if (adv[4]) begin
      s4_sm_r   <= s3_sm_r;
      s4_qh_r   <= qh_nxt;
      s4_v_r    <= v_nxt;
      s4_dneg_r <= s3_dneg_r;
      s4_full_r <= s3_full_r;
    end
    if (adv[5]) begin
      s5_sm_r   <= s4_sm_r;
      s5_qh_r   <= s4_qh_r;
      s5_ql0_r  <= ql0_nxt;
      s5_v_r    <= s4_v_r;
      s5_dneg_r <= s4_dneg_r;
      s5_full_r <= s4_full_r;
    end
    if (adv[6]) begin
      out_sm_r   <= s5_sm_r;
      out_sl_r   <= sl_nxt;
      out_full_r <= s5_full_r;
    end
  end

  assign out_ch.valid       = v_r[NSTG-1];
  assign out_ch.smoothed    = out_sm_r;
  assign out_ch.slope       = out_sl_r;
  assign out_ch.window_full = out_full_r;

endmodule

`default_nettype wire

### design/sgs_chk.sv
`default_nettype none

module sgs_chk (
  input wire logic             clk,
  input wire logic             rst_n,
  input wire logic             in_ready,
  input wire logic             out_valid,
  input wire logic             out_ready,
  input wire sgs_pkg::smooth_t out_smoothed,
  input wire sgs_pkg::slope_t  out_slope,
  input wire logic             out_window_full
);

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result shown right after reset");

  a_valid_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  a_data_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=>
      $stable(out_smoothed) && $stable(out_slope) && $stable(out_window_full))
    else $error("stalled result changed");

  a_ready_when_drained: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input blocked with no result pending");

  a_full_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_window_full |=> !out_valid || out_window_full)
    else $error("window full flag fell");

endmodule

bind savitzky_golay_smooth_and_slope_core sgs_chk u_sgs_chk (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_ready        (in_ch.ready),
  .out_valid       (out_ch.valid),
  .out_ready       (out_ch.ready),
  .out_smoothed    (out_ch.smoothed),
  .out_slope       (out_ch.slope),
  .out_window_full (out_ch.window_full)
);

`default_nettype wire

### tb/savitzky_golay_smooth_and_slope_core_test.sv
module savitzky_golay_smooth_and_slope_core_test;
  import sgs_pkg::*;

  localparam int WINDOW_HELD = 10;
  localparam int WINDOW_LEN  = 11;
  localparam longint SMOOTH_NORM = 429;
  localparam longint SLOPE_NORM  = 5148;
  localparam int DIRECTED_ROWS = 25;

  typedef struct packed {
    smooth_t smoothed;
    slope_t  slope;
    logic    window_full;
  } sg_result_t;

  typedef struct packed {
    sample_t    sample;
    logic       typed;
    sg_result_t want;
  } dir_row_t;

  typedef enum {NO_PAUSE, RX_HOLD_OFF, TX_DRAIN} pressure_t;
  typedef enum {BURST_UNIFORM, BURST_RAILS, BURST_LEVEL, BURST_RAMP, BURST_PEAK} burst_t;

  logic   clk;
  logic   rst_n;
  logic   cfg_we;
  recip_t cfg_wdata;

  sgs_in_if  in_ch ();
  sgs_out_if out_ch ();

  savitzky_golay_smooth_and_slope_core uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

  sample_t    held_samples [WINDOW_HELD];
  int         held_count;
  recip_t     interval;
  sg_result_t smooth_slope_due [$];
  dir_row_t   dir_rows [DIRECTED_ROWS];

  bit steady;
  bit hold_off_req;
  int mismatches;
  int samples_sent;
  int results_checked;
  int rail_hits;
  int interval_settings;

  initial begin
    clk = 1'b0;
  end

  always #5 clk = ~clk;

  initial begin
    #2000000;
    $display("timeout with %0d results outstanding", smooth_slope_due.size());
    $display("** savitzky_golay_smooth_and_slope_core: FAILED **");
    $finish;
  end

  function automatic longint smooth_coef(input int k);
    case (k < 6 ? k : 10 - k)
      0: return -36;
      1: return 9;
      2: return 44;
      3: return 69;
      4: return 84;
      default: return 89;
    endcase
  endfunction

  function automatic longint slope_coef(input int k);
    longint c;
    case (k < 6 ? k : 10 - k)
      0: c = 300;
      1: c = -294;
      2: c = -532;
      3: c = -503;
      4: c = -296;
      default: c = 0;
    endcase
    return (k < 6) ? c : -c;
  endfunction

  // nearest, ties away from zero
  function automatic longint round_div(input longint num, input longint den);
    longint mag;
    longint q;
    mag = (num < 0) ? -num : num;
    q = (mag + den / 2) / den;
    return (num < 0) ? -q : q;
  endfunction

  function automatic longint clamp(input longint v, input longint lo, input longint hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  function automatic sg_result_t sg_filter_step(input sample_t s);
    longint smooth_acc;
    longint slope_acc;
    longint tap;
    sg_result_t r;
    int k;
    smooth_acc = 0;
    slope_acc = 0;
    for (k = 0; k < WINDOW_LEN; k++) begin
      tap = (k < WINDOW_HELD) ? longint'(held_samples[k]) : longint'(s);
      smooth_acc += smooth_coef(k) * tap;
      slope_acc += slope_coef(k) * tap;
    end
    r.smoothed = smooth_t'(clamp(round_div(smooth_acc, SMOOTH_NORM), -32768, 32767));
    r.slope = slope_t'(clamp(round_div(slope_acc * longint'(interval),
                                       SLOPE_NORM * (longint'(1) << RECIP_FRAC_BITS)),
                             -8388608, 8388607));
    r.window_full = (held_count >= WINDOW_HELD);
    for (k = 0; k < WINDOW_HELD - 1; k++) begin
      held_samples[k] = held_samples[k + 1];
    end
    held_samples[WINDOW_HELD - 1] = s;
    if (held_count < WINDOW_HELD) begin
      held_count++;
    end
    return r;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (steady || r < 65) begin
      return 0;
    end else if (r < 93) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(8, 25);
  endfunction

  task automatic send_sample(input sample_t s, input logic typed, input sg_result_t want);
    sg_result_t predicted;
    int gap;
    in_ch.valid <= 1'b1;
    in_ch.sample <= s;
    @(posedge clk);
    while (!in_ch.ready) begin
      @(posedge clk);
    end
    predicted = sg_filter_step(s);
    smooth_slope_due.push_back(typed ? want : predicted);
    samples_sent++;
    if (predicted.smoothed == 32767 || predicted.smoothed == -32768) begin
      rail_hits++;
    end
    gap = pick_gap();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    while (smooth_slope_due.size() != 0) begin
      @(posedge clk);
    end
  endtask

  task automatic set_interval(input recip_t v);
    wait_drained();
    repeat (12) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    interval = v;
    interval_settings++;
  endtask

  task automatic run_random(input int count, input pressure_t action);
    burst_t kind;
    int done;
    int len;
    int base;
    int delta;
    int v;
    int k;
    int r;
    bit flip;
    done = 0;
    while (done < count) begin
      r = $urandom_range(0, 9);
      kind = (r < 3) ? BURST_UNIFORM : (r < 5) ? BURST_RAILS : (r < 7) ? BURST_LEVEL :
             (r < 9) ? BURST_RAMP : BURST_PEAK;
      len = (kind == BURST_PEAK) ? WINDOW_LEN : $urandom_range(1, 16);
      base = $urandom_range(0, 65535) - 32768;
      delta = $urandom_range(0, 6000) - 3000;
      flip = 1'($urandom_range(0, 1));
      for (k = 0; k < len && done < count; k++) begin
        case (kind)
          BURST_UNIFORM: v = $urandom_range(0, 65535);
          BURST_RAILS: begin
            case ($urandom_range(0, 4))
              0: v = 32767;
              1: v = -32768;
              2: v = 0;
              3: v = 1;
              default: v = -1;
            endcase
          end
          BURST_LEVEL: v = int'(clamp(base + int'($urandom_range(0, 400)) - 200,
                                      -32768, 32767));
          BURST_RAMP: v = base + k * delta;
          default: begin
            // rims against a plateau push the smoothed value to the rails
            v = (k == 0 || k == WINDOW_LEN - 1) ? -32768 : 32767;
            if (flip) begin
              v = -1 - v;
            end
          end
        endcase
        send_sample(sample_t'(v), 1'b0, '0);
        done++;
        if (done == count / 2) begin
          case (action)
            RX_HOLD_OFF: hold_off_req = 1'b1;
            TX_DRAIN: wait_drained();
            default: ;
          endcase
        end
      end
    end
  endtask

  initial begin : result_drain
    int r;
    int n;
    out_ch.ready <= 1'b0;
    @(posedge clk);
    while (!rst_n) begin
      @(posedge clk);
    end
    forever begin
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        out_ch.ready <= 1'b0;
        n = 60;
      end else if (steady) begin
        out_ch.ready <= 1'b1;
        n = 1;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 70) begin
          out_ch.ready <= 1'b1;
          n = $urandom_range(1, 4);
        end else if (r < 95) begin
          out_ch.ready <= 1'b0;
          n = $urandom_range(1, 3);
        end else begin
          out_ch.ready <= 1'b0;
          n = $urandom_range(8, 30);
        end
      end
      repeat (n) @(posedge clk);
    end
  end

  always @(posedge clk) begin : check_results
    sg_result_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (smooth_slope_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("unexpected result: smoothed=%0d slope=%0d full=%0b",
                   out_ch.smoothed, out_ch.slope, out_ch.window_full);
        end
      end else begin
        want = smooth_slope_due.pop_front();
        results_checked++;
        if (out_ch.smoothed !== want.smoothed || out_ch.slope !== want.slope ||
            out_ch.window_full !== want.window_full) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("result %0d: expected smoothed=%0d slope=%0d full=%0b, got %0d %0d %0b",
                     results_checked, want.smoothed, want.slope, want.window_full,
                     out_ch.smoothed, out_ch.slope, out_ch.window_full);
          end
        end
      end
    end
  end

  initial begin : stimulus
    int i;
    rst_n <= 1'b0;
    cfg_we <= 1'b0;
    cfg_wdata <= '0;
    in_ch.valid <= 1'b0;
    in_ch.sample <= '0;
    steady = 1'b0;
    hold_off_req = 1'b0;
    mismatches = 0;
    samples_sent = 0;
    results_checked = 0;
    rail_hits = 0;
    interval_settings = 1;
    for (i = 0; i < WINDOW_HELD; i++) begin
      held_samples[i] = '0;
    end
    held_count = 0;
    interval = recip_t'(1 << RECIP_FRAC_BITS);

    // empty window, constant window (no slope), plateau between low rims
    dir_rows = '{
      '{16'sd0,      1'b1, '{16'sd0, 24'sd0, 1'b0}},
      '{16'sd32767,  1'b0, '0}, '{16'sd32767, 1'b0, '0}, '{16'sd32767, 1'b0, '0},
      '{16'sd32767,  1'b0, '0}, '{16'sd32767, 1'b0, '0}, '{16'sd32767, 1'b0, '0},
      '{16'sd32767,  1'b0, '0}, '{16'sd32767, 1'b0, '0}, '{16'sd32767, 1'b0, '0},
      '{16'sd32767,  1'b0, '0},
      '{16'sd32767,  1'b1, '{16'sd32767, 24'sd0, 1'b1}},
      '{-16'sd32768, 1'b0, '0},
      '{16'sd32767,  1'b0, '0}, '{16'sd32767, 1'b0, '0}, '{16'sd32767, 1'b0, '0},
      '{16'sd32767,  1'b0, '0}, '{16'sd32767, 1'b0, '0}, '{16'sd32767, 1'b0, '0},
      '{16'sd32767,  1'b0, '0}, '{16'sd32767, 1'b0, '0}, '{16'sd32767, 1'b0, '0},
      '{-16'sd32768, 1'b1, '{16'sd32767, 24'sd0, 1'b1}},
      '{16'sd1,      1'b0, '0},
      '{-16'sd1,     1'b0, '0}
    };

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    for (i = 0; i < DIRECTED_ROWS; i++) begin
      send_sample(dir_rows[i].sample, dir_rows[i].typed, dir_rows[i].want);
    end

    set_interval(16'd65535);
    run_random(70, RX_HOLD_OFF);
    set_interval(16'd1);
    run_random(70, NO_PAUSE);
    steady = 1'b1;
    set_interval(recip_t'($urandom_range(2, 65534)));
    run_random(70, NO_PAUSE);
    steady = 1'b0;
    set_interval(16'd0);
    run_random(70, TX_DRAIN);
    set_interval(16'd256);
    run_random(75, NO_PAUSE);
    set_interval(recip_t'($urandom_range(2, 65534)));
    run_random(70, NO_PAUSE);

    wait_drained();
    repeat (20) @(posedge clk);

    $display("sent %0d samples over %0d interval settings (zero, 1, 65535, 1.0, random)",
             samples_sent, interval_settings);
    $display("checked %0d results, %0d with smoothed value at a rail, %0d mismatches",
             results_checked, rail_hits, mismatches);
    if (mismatches == 0) begin
      $display("** savitzky_golay_smooth_and_slope_core: PASSED **");
    end else begin
      $display("** savitzky_golay_smooth_and_slope_core: FAILED **");
    end
    $finish;
  end

endmodule

### filelist.f
design/sgs_pkg.sv
design/sgs_in_if.sv
design/sgs_out_if.sv
design/sgs_cell.sv
design/sgs_post.sv
design/savitzky_golay_smooth_and_slope_core.sv
design/sgs_chk.sv
tb/savitzky_golay_smooth_and_slope_core_test.sv
